// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the binomial row block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition and consequence checked at the same clock edge
`define BPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked at the clock edge after the condition
`define BPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpr_pkg.sv -----
// ----------------------------------------------------------------------------
// bpr_pkg
// widths, constants, types and the modular add for the binomial row block
// ----------------------------------------------------------------------------
package bpr_pkg;

    // field and bus widths
    localparam int N_W      = 10;
    localparam int COEF_W   = 30;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // largest set size handled by default
    localparam int MAX_SET_DEF = 1023;

    // modulus 10^9+7
    localparam logic [COEF_W-1:0] MOD_PRIME = 30'd1000000007;

    // status from the row engine to the stream wrapper
    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

    // (a + b) mod prime, both operands below the prime
    function automatic logic [COEF_W-1:0] add_mod(input logic [COEF_W-1:0] a,
                                                 input logic [COEF_W-1:0] b);
        logic [COEF_W:0] sum;
        logic [COEF_W:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = sum - {1'b0, MOD_PRIME};
        if (sum >= {1'b0, MOD_PRIME})
            return red[COEF_W-1:0];
        else
            return sum[COEF_W-1:0];
    endfunction

endpackage

// ----- hdl/bpr_ram.sv -----
// ----------------------------------------------------------------------------
// bpr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpr_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bpr_engine.sv -----
// ----------------------------------------------------------------------------
// bpr_engine
// sequencer that builds pascal rows up to row n in the row memory, one add per cycle within a row
// ----------------------------------------------------------------------------
module bpr_engine #(
    parameter int MAX_SET = bpr_pkg::MAX_SET_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bpr_pkg::N_W-1:0]   set_size,
    input  logic [bpr_pkg::N_W-1:0]   choose_count,
    input  logic                      out_free,
    output bpr_pkg::eng_stat_t        stat,
    output logic [bpr_pkg::COEF_W-1:0] result
);

    import bpr_pkg::*;

    localparam int ROW_DEPTH = MAX_SET / 2 + 1;
    localparam int ADDR_W    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam logic [16:0] MAX_SET_L = 17'(MAX_SET);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_ROW   = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_FETCH = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [N_W-1:0]    n_reg, n_next;
    logic [N_W-1:0]    r_reg, r_next;
    logic [N_W-1:0]    i_reg, i_next;
    logic [N_W-1:0]    j_reg, j_next;
    logic [N_W-1:0]    top_reg, top_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_first_reg, rd_first_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [COEF_W-1:0] prev_reg;
    logic [COEF_W-1:0] res_reg, res_next;

    // memory port signals
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [COEF_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [COEF_W-1:0] mem_rdata;

    // input checks and folding to the smaller side
    logic [N_W-1:0] diff;
    logic [N_W-1:0] fold;
    logic           bad_item;
    logic [N_W-1:0] i_inc;
    logic [N_W-1:0] top_inc;

    assign diff     = set_size - choose_count;
    assign fold     = (choose_count > diff) ? diff : choose_count;
    assign bad_item = (choose_count > set_size) || (17'(set_size) > MAX_SET_L);
    assign i_inc    = i_reg + N_W'(1);
    assign top_inc  = (i_inc < r_reg) ? i_inc : r_reg;

    bpr_ram #(
        .WIDTH (COEF_W),
        .DEPTH (ROW_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_row_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // write mux: clearing sweep or read-modify-write of the row
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(j_reg);
            mem_wdata = (j_reg == '0) ? COEF_W'(1) : '0;
        end
        else
        begin
            mem_we    = rd_vld_reg && !rd_first_reg;
            mem_waddr = rd_addr_reg + ADDR_W'(1);
            mem_wdata = add_mod(prev_reg, mem_rdata);
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        top_next      = top_reg;
        res_next      = res_reg;
        rd_vld_next   = 1'b0;
        rd_first_next = 1'b0;
        rd_addr_next  = rd_addr_reg;
        mem_re        = 1'b0;
        mem_raddr     = ADDR_W'(j_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next = set_size;
                    if (bad_item)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (fold == '0)
                    begin
                        res_next   = COEF_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        r_next     = fold;
                        j_next     = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (j_reg == r_reg)
                begin
                    i_next     = N_W'(1);
                    top_next   = N_W'(1);
                    j_next     = N_W'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    j_next = j_reg + N_W'(1);
                end
            end
            ST_ROW:
            begin
                mem_re        = 1'b1;
                rd_vld_next   = 1'b1;
                rd_first_next = (j_reg == top_reg);
                rd_addr_next  = ADDR_W'(j_reg);
                if (j_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg - N_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // last write of the row lands here, before the next row reads
                if (i_reg == n_reg)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    i_next     = i_inc;
                    top_next   = top_inc;
                    j_next     = top_inc;
                    state_next = ST_ROW;
                end
            end
            ST_FETCH:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(r_reg);
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                res_next   = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        r_reg       <= r_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        top_reg     <= top_next;
        res_reg     <= res_next;
        rd_addr_reg <= rd_addr_next;
        if (rd_vld_reg)
        begin
            prev_reg <= mem_rdata;
        end
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign result         = res_reg;

endmodule

// ----- hdl/binomial_pascal_row_modular.sv -----
// ----------------------------------------------------------------------------
// binomial_pascal_row_modular
// n choose r modulo 10^9+7, built one pascal row at a time in a row memory
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)
// s_*      in   set_size[9:0], choose_count[19:10], zero pad [23:20]
// m_*      out  coefficient[29:0], zero pad [31:30]
//
// a word with r above n, or a trivial fold (r or n-r zero), goes straight to its result
// otherwise, with r folded to min(r, n-r), a word builds rows 1 to n in turn; one
//   row memory access per cycle on the read port bounds the work within a row
// one word is in work at a time; the next is taken while a result waits
// reset needs no clearing pass: each word clears the entries it uses
// ----------------------------------------------------------------------------
module binomial_pascal_row_modular #(
    parameter int MAX_SET = bpr_pkg::MAX_SET_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpr_pkg::S_DATA_W-1:0]  s_tdata,   // set_size, choose_count
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpr_pkg::M_DATA_W-1:0]  m_tdata    // coefficient
);

    import bpr_pkg::*;

    eng_stat_t         stat;
    logic [COEF_W-1:0] result;
    logic              out_free;
    logic              start;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [COEF_W-1:0] coef_reg;

    // input handshake
    assign s_tready = stat.idle;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    bpr_engine #(
        .MAX_SET(MAX_SET)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .set_size    (s_tdata[N_W-1:0]),
        .choose_count(s_tdata[2*N_W-1:N_W]),
        .out_free    (out_free),
        .stat        (stat),
        .result      (result)
    );

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (stat.res_valid && out_free)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid && out_free)
        begin
            coef_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-COEF_W){1'b0}}, coef_reg};

endmodule

// ----- hdl/bpr_chk.sv -----
// ----------------------------------------------------------------------------
// bpr_chk
// port level checks for the binomial row block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpr_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bpr_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bpr_pkg::M_DATA_W-1:0]  m_tdata
);

    import bpr_pkg::*;

    logic in_word;
    logic coef_ok;

    assign in_word = s_tvalid && s_tready && (s_tdata[S_DATA_W-1] == 1'b0 || 1'b1);
    assign coef_ok = (m_tdata[COEF_W-1:0] < MOD_PRIME) && (m_tdata[M_DATA_W-1:COEF_W] == '0);

    // a taken word keeps the block busy in the cycle after it is taken
    `BPR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_word, !s_tready, "ready after accept")

    // a result is always reduced below the prime with zero padding
    `BPR_ASSERT_NOW(a_coef_range, clk, rst_n, m_tvalid, coef_ok, "coefficient out of range")

    // a new result only comes from a word in work
    `BPR_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(m_tvalid), $past(!s_tready),
        "result without a word in work")

    // a stalled result holds
    `BPR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind binomial_pascal_row_modular bpr_chk u_bpr_chk (.*);
